/* rtl/ttu_pkg.sv */
package ttu_pkg;

    localparam int REC_W      = 32;
    localparam int CHAN_W     = 4;
    localparam int PERIOD_W   = 40;
    localparam int STEP_W     = 32;
    localparam int OUT_TIME_W = 41;
    localparam int TAG_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    localparam logic [CHAN_W-1:0] OVFL_CODE = 4'hF;

    localparam logic [CFG_IDX_W-1:0] REG_TAG_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_STEP = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd409600000;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 32'd210698240;

    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [PERIOD_W-1:0]   period_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [TAG_W-1:0]      tag_t;

endpackage

/* rtl/ttu_serial_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
module ttu_serial_div #(
    parameter int DIVIDEND_W = 56,
    parameter int DIVISOR_W  = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, num_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = trial >= {1'b0, divisor};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            // remainder stays below the divisor, so the low bits suffice
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/time_tag_record_unwrapper.sv */
// Overflow marker records: no item out; the excess is updated in the cycle after accept (PREP),
// then the block returns to IDLE for the next accept. Time records: after accept, PREP, then
// DIV while a tag wrap needs the bit-serial divider (one quotient bit per cycle), then OUT.
// One record is in work at a time; the next can be accepted in the cycle after the result
// is loaded into the output register in OUT, which waits while the receiver stalls.
// Synchronous active-low reset clears excess and tag counter and loads register defaults.
module time_tag_record_unwrapper #(
    parameter int TIME_BITS    = 28,
    parameter int FRAC_BITS    = 8,
    parameter int EXCESS_WIDTH = 56
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ttu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ttu_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ttu_pkg::REC_W-1:0]            s_record_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_second_channel,
    output logic [ttu_pkg::CHAN_W-1:0]           m_channel_code,
    output logic [ttu_pkg::TAG_W-1:0]            m_tag_count,
    output logic signed [ttu_pkg::OUT_TIME_W-1:0] m_time_in_tag_q8
);

    localparam int TW    = TIME_BITS + FRAC_BITS;
    localparam int EW    = EXCESS_WIDTH;
    localparam int PW    = ttu_pkg::PERIOD_W;
    localparam int OW    = ttu_pkg::OUT_TIME_W;
    localparam int SUM_W = ((EW > TW + 1) ? EW : TW + 1) + 1;
    localparam int UW    = SUM_W - 1;
    localparam int AW    = ((EW > ttu_pkg::STEP_W + FRAC_BITS + 1) ?
                            EW : ttu_pkg::STEP_W + FRAC_BITS + 1) + 1;
    localparam int DW    = ((EW > PW + 2) ? EW : PW + 2) + ((TW + 1 > EW) ? TW + 1 : 0);

    localparam logic signed [AW-1:0]    EXC_MAX = (AW'(1) <<< (EW - 1)) - AW'(1);
    localparam logic signed [SUM_W-1:0] OUT_HI  = (SUM_W'(1) <<< (OW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] OUT_LO  = -OUT_HI - SUM_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    ttu_pkg::period_t           period_reg;
    ttu_pkg::step_t             step_reg;
    logic signed [EW-1:0]       excess_reg, excess_next;
    ttu_pkg::tag_t              tag_reg, tag_next;
    logic [ttu_pkg::REC_W-1:0]  rec_reg;
    logic signed [OW-1:0]       res_time_reg, res_time_next;

    logic                       m_valid_reg;
    logic                       m_second_channel_reg;
    ttu_pkg::chan_t             m_channel_code_reg;
    ttu_pkg::tag_t              m_tag_count_reg;
    logic signed [OW-1:0]       m_time_in_tag_reg;

    logic [ttu_pkg::REC_W-1:0]  rec_shift;
    ttu_pkg::chan_t             chan;
    logic [TW-1:0]              t_q;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_m1;
    logic signed [SUM_W-1:0]    sum_clamped;
    logic signed [AW-1:0]       ovf_sum;
    logic                       need_div;
    logic                       out_free;

    logic                       div_start;
    logic                       div_done;
    logic [UW-1:0]              div_quo;
    logic [PW-1:0]              div_rem;
    logic [PW:0]                r_val;
    logic signed [DW-1:0]       new_excess;

    always_comb begin
        rec_shift = rec_reg >> TIME_BITS;
        chan      = rec_shift[ttu_pkg::CHAN_W-1:0];
        t_q       = TW'(rec_reg[TIME_BITS-1:0]) << FRAC_BITS;
        sum       = SUM_W'(excess_reg) + $signed(SUM_W'(t_q));
        sum_m1    = sum - SUM_W'(1);
        ovf_sum   = AW'(excess_reg) + $signed(AW'(step_reg) << FRAC_BITS);
        // reduce only a positive sum strictly above a nonzero period
        need_div  = (sum > 0) && (period_reg != '0) && (sum > $signed(SUM_W'(period_reg)));
        if (sum > OUT_HI) begin
            sum_clamped = OUT_HI;
        end else if (sum < OUT_LO) begin
            sum_clamped = OUT_LO;
        end else begin
            sum_clamped = sum;
        end
        r_val      = {1'b0, div_rem} + (PW + 1)'(1);
        new_excess = $signed(DW'(r_val)) - $signed(DW'(t_q));
        out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next    = state_reg;
        excess_next   = excess_reg;
        tag_next      = tag_reg;
        res_time_next = res_time_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (chan == ttu_pkg::OVFL_CODE) begin
                    excess_next = (ovf_sum > EXC_MAX) ? EW'(EXC_MAX) : EW'(ovf_sum);
                    state_next  = ST_IDLE;
                end else if (need_div) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    res_time_next = OW'(sum_clamped);
                    state_next    = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    tag_next      = tag_reg + ttu_pkg::TAG_W'(div_quo);
                    excess_next   = EW'(new_excess);
                    res_time_next = $signed(OW'(r_val));
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ttu_serial_div #(
        .DIVIDEND_W (UW),
        .DIVISOR_W  (PW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum_m1[UW-1:0]),
        .divisor   (period_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            period_reg  <= ttu_pkg::PERIOD_RESET;
            step_reg    <= ttu_pkg::STEP_RESET;
            excess_reg  <= '0;
            tag_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            excess_reg <= excess_next;
            tag_reg    <= tag_next;
            if (cfg_wr_en) begin
                if (cfg_index == ttu_pkg::REG_TAG_PERIOD) begin
                    period_reg <= cfg_wr_data[PW-1:0];
                end
                if (cfg_index == ttu_pkg::REG_OVERFLOW_STEP) begin
                    step_reg <= cfg_wr_data[ttu_pkg::STEP_W-1:0];
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        res_time_reg <= res_time_next;
        if (state_reg == ST_IDLE && s_valid) begin
            rec_reg <= s_record_word;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_second_channel_reg <= (chan != '0);
            m_channel_code_reg   <= chan;
            m_tag_count_reg      <= tag_reg;
            m_time_in_tag_reg    <= res_time_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_second_channel = m_second_channel_reg;
    assign m_channel_code   = m_channel_code_reg;
    assign m_tag_count      = m_tag_count_reg;
    assign m_time_in_tag_q8 = m_time_in_tag_reg;

endmodule

/* dv/time_tag_record_unwrapper_tb.sv */
module time_tag_record_unwrapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake of any kind
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int SETTLE        = 70;    // a marker can still be in work when the queue empties
    localparam int CLAMP_MARKERS = 4;     // max-step markers that push the sum past the output range
    localparam int PHASE_ITEMS   = 205;
    localparam int NUM_ROWS      = 31;

    localparam longint EXCESS_MAX = (longint'(1) << 55) - 1;
    localparam longint TIME_HI    = (longint'(1) << 40) - 1;
    localparam longint TIME_LO    = -TIME_HI - 1;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_e;
    typedef enum logic {ROW_RECORD, ROW_WRITE} row_kind_e;

    typedef struct packed {
        logic                                   second_ch;
        ttu_pkg::chan_t                         chan;
        ttu_pkg::tag_t                          tag;
        logic signed [ttu_pkg::OUT_TIME_W-1:0]  time_q8;
    } tag_result_t;

    typedef struct packed {
        row_kind_e                          kind;
        logic [ttu_pkg::CFG_IDX_W-1:0]      index;
        logic [ttu_pkg::CFG_DATA_W-1:0]     word;
        logic                               typed;
        tag_result_t                        want;
    } stim_row_t;

    logic                                   aclk;
    logic                                   aresetn          = 1'b0;
    logic                                   cfg_wr_en        = 1'b0;
    logic [ttu_pkg::CFG_IDX_W-1:0]          cfg_index        = '0;
    logic [ttu_pkg::CFG_DATA_W-1:0]         cfg_wr_data      = '0;
    logic                                   s_valid          = 1'b0;
    logic                                   s_ready;
    logic [ttu_pkg::REC_W-1:0]              s_record_word    = '0;
    logic                                   m_valid;
    logic                                   m_ready          = 1'b0;
    logic                                   m_second_channel;
    ttu_pkg::chan_t                         m_channel_code;
    ttu_pkg::tag_t                          m_tag_count;
    logic signed [ttu_pkg::OUT_TIME_W-1:0]  m_time_in_tag_q8;

    flow_e       flow      = FLOW_FREE;
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          quiet     = 0;
    int          mismatches = 0;
    tag_result_t tags_due[$];

    // shadow copy of the block state and registers
    ttu_pkg::period_t shadow_period;
    ttu_pkg::step_t   shadow_step;
    longint           shadow_excess;
    ttu_pkg::tag_t    shadow_tags;

    stim_row_t   directed [NUM_ROWS];

    time_tag_record_unwrapper dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_record_word    (s_record_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_second_channel (m_second_channel),
        .m_channel_code   (m_channel_code),
        .m_tag_count      (m_tag_count),
        .m_time_in_tag_q8 (m_time_in_tag_q8)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic note_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Record decode, overflow-marker excess update, excess/period reduction and output clamp.
    function automatic void unwrap_record(input logic [ttu_pkg::REC_W-1:0] w, output bit emits,
                                          output tag_result_t res);
        ttu_pkg::chan_t    chan;
        longint            t;
        longint            add;
        longint            s;
        longint            rem;
        longint unsigned   u;
        longint unsigned   n;
        longint unsigned   r;
        bit                positive;
        chan = w[31:28];
        t = longint'(w[27:0]) << 8;
        res = '0;
        emits = 1'b0;
        if (chan == ttu_pkg::OVFL_CODE) begin
            add = longint'(shadow_step) << 8;
            if (shadow_excess > EXCESS_MAX - add)
                shadow_excess = EXCESS_MAX;
            else
                shadow_excess += add;
            return;
        end
        u = 0;
        if (shadow_excess >= 0) begin
            u = unsigned'(shadow_excess) + unsigned'(t);
            positive = 1'b1;
            rem = 0;
        end else begin
            s = shadow_excess + t;
            positive = (s > 0);
            if (positive)
                u = unsigned'(s);
            rem = s;
        end
        if (positive) begin
            if (shadow_period != '0 && u > 64'(shadow_period)) begin
                // largest count that leaves the remainder in (0, period]
                n = (u - 1) / 64'(shadow_period);
                r = u - n * 64'(shadow_period);
                shadow_tags += n;
                shadow_excess = longint'(r) - t;
                rem = longint'(r);
            end else begin
                rem = longint'(u);
            end
        end
        if (rem > TIME_HI)
            rem = TIME_HI;
        if (rem < TIME_LO)
            rem = TIME_LO;
        emits = 1'b1;
        res.second_ch = (chan != '0);
        res.chan = chan;
        res.tag = shadow_tags;
        res.time_q8 = rem[ttu_pkg::OUT_TIME_W-1:0];
    endfunction

    task automatic idle_cycle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic feed_record(input logic [ttu_pkg::REC_W-1:0] w, input logic typed,
                               input tag_result_t want);
        int          gap_pct;
        bit          emits;
        tag_result_t res;
        gap_pct = (flow == FLOW_SRC_IDLE) ? 82 : (flow == FLOW_BOTH) ? 14 : 0;
        while ($urandom_range(99) < gap_pct)
            idle_cycle();
        s_valid <= 1'b1;
        s_record_word <= w;
        do
            @(posedge aclk);
        while (!s_ready);
        unwrap_record(w, emits, res);
        if (emits)
            tags_due.push_back(typed ? want : res);
    endtask

    task automatic drain();
        while (tags_due.size() != 0)
            idle_cycle();
    endtask

    task automatic write_reg(input logic [ttu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttu_pkg::CFG_DATA_W-1:0] val);
        drain();
        repeat (SETTLE) idle_cycle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ttu_pkg::REG_TAG_PERIOD)
            shadow_period = val[ttu_pkg::PERIOD_W-1:0];
        else
            shadow_step = val[ttu_pkg::STEP_W-1:0];
    endtask

    function automatic logic [ttu_pkg::REC_W-1:0] random_record();
        logic [ttu_pkg::REC_W-1:0] w;
        int                        pick;
        w = $urandom();
        pick = $urandom_range(99);
        if (pick < 15)
            w[31:28] = ttu_pkg::OVFL_CODE;
        else if (w[31:28] == ttu_pkg::OVFL_CODE)
            w[31:28] = 4'($urandom_range(14));
        if (pick >= 15 && pick < 25)
            w[27:0] = '1;
        else if (pick >= 25 && pick < 30)
            w[27:0] = '0;
        return w;
    endfunction

    function automatic stim_row_t rec_row(input logic [ttu_pkg::REC_W-1:0] w);
        stim_row_t row;
        row = '0;
        row.kind = ROW_RECORD;
        row.word = ttu_pkg::CFG_DATA_W'(w);
        return row;
    endfunction

    function automatic stim_row_t chk_row(input logic [ttu_pkg::REC_W-1:0] w, input logic sc,
                                          input ttu_pkg::chan_t ch, input ttu_pkg::tag_t tag,
                                          input longint tm);
        stim_row_t row;
        row = rec_row(w);
        row.typed = 1'b1;
        row.want.second_ch = sc;
        row.want.chan = ch;
        row.want.tag = tag;
        row.want.time_q8 = tm[ttu_pkg::OUT_TIME_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [ttu_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [ttu_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.index = idx;
        row.word = val;
        return row;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin : result_sink
        int stall_pct;
        stall_pct = (flow == FLOW_SINK_STALL) ? 82 : (flow == FLOW_BOTH) ? 14 : 0;
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        tag_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tags_due.size() == 0) begin
                note_error("result item with nothing expected");
            end else begin
                want = tags_due.pop_front();
                if (m_second_channel !== want.second_ch)
                    note_error($sformatf("second_channel %b, want %b",
                                         m_second_channel, want.second_ch));
                if (m_channel_code !== want.chan)
                    note_error($sformatf("channel_code %0d, want %0d",
                                         m_channel_code, want.chan));
                if (m_tag_count !== want.tag)
                    note_error($sformatf("tag_count %0d, want %0d", m_tag_count, want.tag));
                if (m_time_in_tag_q8 !== want.time_q8)
                    note_error($sformatf("time_in_tag_q8 %0d, want %0d",
                                         m_time_in_tag_q8, want.time_q8));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("time_tag_record_unwrapper_tb failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        int               ph;
        int               k;
        logic [39:0]      rnd_period;
        logic [31:0]      rnd_step;

        shadow_period = ttu_pkg::PERIOD_RESET;
        shadow_step = ttu_pkg::STEP_RESET;
        shadow_excess = 0;
        shadow_tags = '0;

        directed = '{
            chk_row(32'h0000_0000, 1'b0, 4'd0, 64'd0, 0),
            chk_row(32'h0000_0100, 1'b0, 4'd0, 64'd0, 65536),
            reg_row(ttu_pkg::REG_TAG_PERIOD, 40'd65536),
            // sum equal to the period: no reduction
            chk_row(32'h0000_0100, 1'b0, 4'd0, 64'd0, 65536),
            chk_row(32'h0000_0101, 1'b0, 4'd0, 64'd1, 256),
            rec_row(32'h0FFF_FFFF),
            // excess now negative, zero time gives a negative remainder
            rec_row(32'hE000_0000),
            rec_row(32'h1000_0001),
            rec_row(32'hF000_0000),
            rec_row(32'hFFFF_FFFF),
            rec_row(32'h8ABC_DEF0),
            reg_row(ttu_pkg::REG_TAG_PERIOD, 40'd1),
            rec_row(32'h0000_0000),
            rec_row(32'h2FFF_FFFF),
            rec_row(32'h5555_5555),
            reg_row(ttu_pkg::REG_TAG_PERIOD, 40'hFF_FFFF_FFFF),
            reg_row(ttu_pkg::REG_OVERFLOW_STEP, 40'hFF_FFFF_FFFF),
            rec_row(32'hF123_4567),
            rec_row(32'hF000_0000),
            rec_row(32'hAAAA_AAAA),
            rec_row(32'h0FFF_FFFF),
            reg_row(ttu_pkg::REG_OVERFLOW_STEP, 40'd1),
            rec_row(32'hF000_0000),
            rec_row(32'h3000_0000),
            // zero period: sum passes through, state untouched
            reg_row(ttu_pkg::REG_TAG_PERIOD, 40'd0),
            rec_row(32'h9FFF_FFFF),
            rec_row(32'h4000_0001),
            reg_row(ttu_pkg::REG_TAG_PERIOD, ttu_pkg::CFG_DATA_W'(ttu_pkg::PERIOD_RESET)),
            reg_row(ttu_pkg::REG_OVERFLOW_STEP, ttu_pkg::CFG_DATA_W'(ttu_pkg::STEP_RESET)),
            rec_row(32'hDEAD_BEEF),
            rec_row(32'h6000_0000)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE)
                write_reg(directed[i].index, directed[i].word);
            else
                feed_record(directed[i].word[ttu_pkg::REC_W-1:0], directed[i].typed,
                            directed[i].want);
        end

        // grow the excess past the output range with period zero, so the output clamps
        write_reg(ttu_pkg::REG_TAG_PERIOD, 40'd0);
        write_reg(ttu_pkg::REG_OVERFLOW_STEP, 40'hFF_FFFF_FFFF);
        for (k = 0; k < CLAMP_MARKERS; k++)
            feed_record({ttu_pkg::OVFL_CODE, 28'($urandom())}, 1'b0, '0);
        feed_record(32'h0000_0000, 1'b0, '0);
        feed_record(32'hEFFF_FFFF, 1'b0, '0);
        write_reg(ttu_pkg::REG_TAG_PERIOD, 40'hFF_FFFF_FFFF);
        feed_record(32'h0123_4567, 1'b0, '0);
        write_reg(ttu_pkg::REG_TAG_PERIOD, 40'd1);
        feed_record(32'h7FFF_FFFF, 1'b0, '0);
        write_reg(ttu_pkg::REG_TAG_PERIOD, ttu_pkg::CFG_DATA_W'(ttu_pkg::PERIOD_RESET));
        write_reg(ttu_pkg::REG_OVERFLOW_STEP, ttu_pkg::CFG_DATA_W'(ttu_pkg::STEP_RESET));

        for (ph = 0; ph < 8; ph++) begin
            if (ph != 0) begin
                rnd_period = 40'({$urandom(), $urandom()} >> $urandom_range(39));
                rnd_step = $urandom() >> $urandom_range(31);
                if (ph == 3) begin
                    rnd_period = 40'd1;
                    rnd_step = '1;
                end else if (ph == 5) begin
                    rnd_period = '1;
                    rnd_step = 32'd1;
                end
                if (rnd_period == '0)
                    rnd_period = 40'd1;
                if (rnd_step == '0)
                    rnd_step = 32'd1;
                write_reg(ttu_pkg::REG_TAG_PERIOD, rnd_period);
                write_reg(ttu_pkg::REG_OVERFLOW_STEP, ttu_pkg::CFG_DATA_W'(rnd_step));
            end
            flow <= flow_e'(ph % 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 50)
                    hold_kick <= ~hold_kick;   // sender keeps offering while the sink is held
                if (ph == 1 && k == 100)
                    drain();
                feed_record(random_record(), 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE) idle_cycle();
        if (mismatches == 0 && tags_due.size() == 0)
            $display("time_tag_record_unwrapper_tb passed");
        else
            $display("time_tag_record_unwrapper_tb failed");
        $finish;
    end

endmodule
